FILE: rtl/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared constants, types and character helpers for the radix text converter.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int VALUE_BITS_DEF = 63;
    localparam int MAX_DIGITS_DEF = 64;

    localparam int BASE_W    = 6;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 1;
    // quotient bits resolved per divider cycle
    localparam int DIV_STEP  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 1'd1;

    localparam logic [BASE_W-1:0] BASE_MIN       = 6'd2;
    localparam logic [BASE_W-1:0] DIGIT_LIMIT    = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET     = 6'd10;
    localparam logic [BASE_W-1:0] DECIMAL_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z    = 8'h5A;

    typedef struct packed {
        logic done;
        logic quot_zero;
    } t_div_status;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > DIGIT_LIMIT) begin
            r = DIGIT_LIMIT;
        end
        return r;
    endfunction

    function automatic logic [BASE_W-1:0] char_to_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
        end else if (c >= CH_A && c <= CH_Z) begin
            t = c - CH_A + CHAR_W'(DECIMAL_DIGITS);
        end
        return t[BASE_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d < DECIMAL_DIGITS) begin
            r = CH_ZERO + CHAR_W'(d);
        end else begin
            r = CH_A + CHAR_W'(d - DECIMAL_DIGITS);
        end
        return r;
    endfunction

endpackage

FILE: rtl/rtc_divider.sv
// ----------------------------------------------------------------------------
// rtc_divider
// Iterative divider of a wide value by a small base, several quotient bits
// per cycle; returns quotient and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module rtc_divider #(
    parameter int VALUE_BITS = rtc_pkg::VALUE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [VALUE_BITS-1:0]     i_dividend,
    input  logic [rtc_pkg::BASE_W-1:0] i_divisor,
    output rtc_pkg::t_div_status      o_status,
    output logic [VALUE_BITS-1:0]     o_quotient,
    output logic [rtc_pkg::BASE_W-1:0] o_remainder
);
    import rtc_pkg::*;

    localparam int ITER = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD  = ITER * DIV_STEP;
    localparam int IT_W = $clog2(ITER + 1);

    logic [PAD-1:0]    r_quo;
    logic [BASE_W-1:0] r_rem;
    logic [BASE_W-1:0] r_div;
    logic [IT_W-1:0]   r_iter;
    logic              r_busy;
    logic              r_done;

    logic [PAD-1:0]    n_quo;
    logic [BASE_W-1:0] n_rem;
    logic [BASE_W:0]   w_trial;

    // restoring division, one quotient bit per inner step
    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        w_trial = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            w_trial = {n_rem, n_quo[PAD-1]};
            n_quo   = {n_quo[PAD-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                w_trial  = w_trial - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = w_trial[BASE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == IT_W'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= PAD'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_status.done      = r_done;
    assign o_status.quot_zero = (r_quo == '0);
    assign o_quotient         = r_quo[VALUE_BITS-1:0];
    assign o_remainder        = r_rem;

endmodule

FILE: rtl/radix_text_converter_top.sv
// ----------------------------------------------------------------------------
// radix_text_converter_top
// Accumulates digit characters in a source base, then emits the value as
// digit characters in a target base, most significant first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                     | payload
//  in      | input     | i_in_valid / o_in_ready       | i_char_code, i_final_char
//  out     | output    | o_out_valid / i_out_ready     | o_digit_code, o_end_of_number,
//          |           |                               | o_empty_value, o_overflowed
//  cfg     | input     | i_cfg_we                      | i_cfg_index, i_cfg_data
//
// a non-final character is a multiply-add into the accumulator
// a final character with a non-zero value runs the shared divider once per
// output digit, then reads each digit from the digit memory and sends it
// o_in_ready is low from the final character until the last word is loaded
// into the output register
// reset is synchronous, active low; bases reset to 10; output stalls hold
module radix_text_converter_top #(
    parameter int VALUE_BITS = rtc_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rtc_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rtc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rtc_pkg::BASE_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rtc_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                          i_final_char,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rtc_pkg::CHAR_W-1:0]    o_digit_code,
    output logic                          o_end_of_number,
    output logic                          o_empty_value,
    output logic                          o_overflowed
);
    import rtc_pkg::*;

    localparam int PW    = VALUE_BITS + BASE_W;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int PTR_W = $clog2(MAX_DIGITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ZERO = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_SEND = 3'd4;

    logic [2:0]            r_state;
    logic [BASE_W-1:0]     r_src_base;
    logic [BASE_W-1:0]     r_tgt_base;
    logic [VALUE_BITS-1:0] r_acc;
    logic                  r_sat;
    logic                  r_num_ovf;
    logic [CNT_W-1:0]      r_cnt;
    logic [PTR_W-1:0]      r_ptr;
    logic [BASE_W-1:0]     r_mem [MAX_DIGITS];
    logic [BASE_W-1:0]     r_rd_data;

    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_digit_code;
    logic                  r_eon;
    logic                  r_empty;
    logic                  r_ovf_out;

    logic [PW-1:0]         w_prod;
    logic                  w_ovf;
    logic [VALUE_BITS-1:0] w_acc_next;
    logic                  w_in_fire;
    logic                  w_out_free;
    logic                  w_div_start;
    logic [VALUE_BITS-1:0] w_div_value;
    logic                  w_div_last;
    logic                  w_load_zero;
    logic                  w_load_digit;
    t_div_status           w_div_st;
    logic [VALUE_BITS-1:0] w_quotient;
    logic [BASE_W-1:0]     w_remainder;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // value*base+digit, wide enough that overflow shows in the top bits
    assign w_prod = PW'(r_acc) * PW'(clamp_base(r_src_base))
                  + PW'(char_to_digit(i_char_code));
    assign w_ovf      = r_sat || (w_prod[PW-1:VALUE_BITS] != '0);
    assign w_acc_next = w_ovf ? '1 : w_prod[VALUE_BITS-1:0];

    // stop after the quotient runs out or the digit memory is full
    assign w_div_last = w_div_st.quot_zero || (r_cnt == CNT_W'(MAX_DIGITS - 1));

    assign w_div_start = (w_in_fire && i_final_char && (w_acc_next != '0))
                       || (r_state == ST_DIV && w_div_st.done && !w_div_last);
    assign w_div_value = (r_state == ST_IDLE) ? w_acc_next : w_quotient;

    assign w_load_zero  = (r_state == ST_ZERO) && w_out_free;
    assign w_load_digit = (r_state == ST_SEND) && w_out_free;

    rtc_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_value),
        .i_divisor   (clamp_base(r_tgt_base)),
        .o_status    (w_div_st),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base <= BASE_RESET;
            r_tgt_base <= BASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SOURCE_BASE: r_src_base <= i_cfg_data;
                REG_TARGET_BASE: r_tgt_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_acc     <= '0;
            r_sat     <= 1'b0;
            r_num_ovf <= 1'b0;
            r_cnt     <= '0;
            r_ptr     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        if (i_final_char) begin
                            r_acc     <= '0;
                            r_sat     <= 1'b0;
                            r_num_ovf <= w_ovf;
                            r_cnt     <= '0;
                            r_state   <= (w_acc_next == '0) ? ST_ZERO : ST_DIV;
                        end else begin
                            r_acc <= w_acc_next;
                            r_sat <= w_ovf;
                        end
                    end
                end
                ST_ZERO: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (w_div_st.done) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (w_div_last) begin
                            r_ptr   <= r_cnt[PTR_W-1:0];
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_SEND;
                end
                ST_SEND: begin
                    if (w_out_free) begin
                        if (r_ptr == '0) begin
                            r_cnt   <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_ptr   <= r_ptr - 1'b1;
                            r_state <= ST_READ;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // digit memory, least significant digit at index zero
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && w_div_st.done) begin
            r_mem[r_cnt[PTR_W-1:0]] <= w_remainder;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_zero || w_load_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_zero) begin
            // a zero value carries no digit character
            r_digit_code <= '0;
            r_eon        <= 1'b1;
            r_empty      <= 1'b1;
            r_ovf_out    <= r_num_ovf;
        end else if (w_load_digit) begin
            r_digit_code <= digit_to_char(r_rd_data);
            r_eon        <= (r_ptr == '0);
            r_empty      <= 1'b0;
            r_ovf_out    <= r_num_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_digit_code    = r_digit_code;
    assign o_end_of_number = r_eon;
    assign o_empty_value   = r_empty;
    assign o_overflowed    = r_ovf_out;

endmodule
